### design/bba_pkg.sv
// Shared types and constants for the first-fit block bitmap allocator.
// Used by block_bitmap_allocator_top and the testbench; depends on nothing.
`default_nettype none

package bba_pkg;

    localparam int BLOCK_W   = 13;
    localparam int CNT_W     = 14;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam logic [CNT_W-1:0] CFG_RESET = 14'd8192;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK           = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL         = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ALREADY_FREE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE        = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_ABIT,
        ST_FDIV,
        ST_FRD,
        ST_FBIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### design/bba_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    aclk,
    input  wire logic                    we,
    input  wire logic [AW-1:0]           waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic [AW-1:0]           raddr,
    output logic      [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/bba_find.sv
// Shared find-first-zero unit: lowest clear bit of a word.
// Serves both the full-word summary scan and the bit pick inside a map word.
`default_nettype none

module bba_find #(
    parameter int WIDTH = 32,
    localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
    input  wire logic [WIDTH-1:0] vec,
    output logic                  found,
    output logic [IW-1:0]         idx
);

    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (!vec[i]) begin
                found = 1'b1;
                idx   = IW'(i);
            end
        end
    end

endmodule

`default_nettype wire

### design/block_bitmap_allocator_top.sv
// First-fit block bitmap allocator top level: sequencer, map RAM, full-word summary.
// Depends on bba_pkg, bba_ram and bba_find.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  tdata: block_number; tuser: action
//  m_        out  m_tvalid/m_tready  tdata: granted_block, free_blocks; tuser: status
//  cfg_      in   cfg_we             cfg_wdata: managed block count
//
// Allocate: ST_SCAN steps through summary chunks of WORD_BITS map words (at most
// MAP_WORDS/WORD_BITS chunks) until one holds a clear bit, ST_ABIT sets it, then ST_DONE;
// a full store goes from the last chunk to ST_DONE. Free: ST_FDIV, ST_FRD, ST_FBIT, ST_DONE,
// or ST_FDIV then ST_DONE when the number is out of range. The shared find unit and the
// single map RAM read port set this sequence. After reset a clearing pass zeroes the map,
// one word a cycle, with s_tready low. A result held in the output register stalls only the
// final step of the next request.
`default_nettype none

module block_bitmap_allocator_top #(
    parameter int MAP_BITS  = 8192,
    parameter int WORD_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [bba_pkg::CNT_W-1:0]       cfg_wdata,    // managed block count
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bba_pkg::S_TDATA_W-1:0]   s_tdata,      // [12:0] block_number
    input  wire logic [0:0]                      s_tuser,      // [0] action
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [bba_pkg::M_TDATA_W-1:0]        m_tdata,      // [12:0] granted_block,
                                                               // [26:13] free_blocks
    output logic [bba_pkg::STAT_W-1:0]           m_tuser       // [1:0] status
);

    localparam int MAP_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int SUM_CHUNKS = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CW         = (SUM_CHUNKS > 1) ? $clog2(SUM_CHUNKS) : 1;
    localparam int IW         = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int BW         = $clog2(MAP_WORDS * WORD_BITS);
    localparam int CNTW       = $clog2(MAP_BITS + 1);
    localparam int XW         = (CNTW > bba_pkg::CNT_W) ? CNTW : bba_pkg::CNT_W;
    localparam int NUMW       = bba_pkg::BLOCK_W;
    localparam int SHK        = NUMW + IW;
    localparam int RECIP      = ((1 << SHK) + WORD_BITS - 1) / WORD_BITS;
    localparam int RW         = $clog2(RECIP + 1);
    localparam int PW         = NUMW + RW;

    bba_pkg::state_t state_reg, state_next;

    logic [bba_pkg::CNT_W-1:0]  cfg_reg;
    logic [WAW-1:0]             clr_addr_reg, clr_addr_next;
    logic [CW-1:0]              chunk_reg, chunk_next;
    logic [WAW-1:0]             chunk_base_reg, chunk_base_next;
    logic [BW-1:0]              block_base_reg, block_base_next;
    logic [WAW-1:0]             word_reg, word_next;
    logic [BW-1:0]              word_base_reg, word_base_next;
    logic [IW-1:0]              bit_reg, bit_next;
    logic [NUMW-1:0]            num_reg, num_next;
    logic [CNTW-1:0]            n_reg, n_next;
    logic [CNTW-1:0]            used_reg, used_next;
    logic [MAP_WORDS-1:0]       full_reg, full_next;
    logic [NUMW-1:0]            res_block_reg, res_block_next;
    logic [bba_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic                       out_valid_reg, out_valid_next;
    logic [NUMW-1:0]            out_block_reg, out_block_next;
    logic [bba_pkg::STAT_W-1:0] out_status_reg, out_status_next;
    logic [bba_pkg::CNT_W-1:0]  out_free_reg, out_free_next;

    logic                        s_accept;
    logic                        out_load;
    logic [CNTW-1:0]             managed;
    logic [XW-1:0]               cfg_ext;
    logic [SUM_CHUNKS*WORD_BITS-1:0] sum_pad;
    logic [WORD_BITS-1:0]        sum_chunk;
    logic [WORD_BITS-1:0]        find_in;
    logic                        f_found;
    logic [IW-1:0]               f_idx;
    logic [WORD_BITS-1:0]        rd_data;
    logic [WAW-1:0]              rd_addr;
    logic                        wr_en;
    logic [WAW-1:0]              wr_addr;
    logic [WORD_BITS-1:0]        wr_data;
    logic [WORD_BITS-1:0]        bit_mask;
    logic [BW-1:0]               bit_sum;
    logic [PW-1:0]               prod;
    logic [PW-1:0]               quot;
    logic [NUMW-1:0]             word_first;
    logic [NUMW-1:0]             rem;
    logic                        last_chunk;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    bba_find #(
        .WIDTH (WORD_BITS)
    ) u_find (
        .vec   (find_in),
        .found (f_found),
        .idx   (f_idx)
    );

    assign s_tready = (state_reg == bba_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == bba_pkg::ST_DONE) && (!out_valid_reg || m_tready);

    assign cfg_ext = XW'(cfg_reg);
    assign managed = (cfg_ext > XW'(MAP_BITS)) ? CNTW'(MAP_BITS) : CNTW'(cfg_ext);

    always_comb begin
        sum_pad = '1;
        for (int i = 0; i < MAP_WORDS; i++) begin
            sum_pad[i] = full_reg[i];
        end
    end

    assign sum_chunk  = sum_pad[chunk_reg * WORD_BITS +: WORD_BITS];
    assign last_chunk = (chunk_reg == CW'(SUM_CHUNKS - 1));
    assign find_in    = (state_reg == bba_pkg::ST_SCAN) ? sum_chunk : rd_data;
    assign rd_addr    = (state_reg == bba_pkg::ST_SCAN) ? chunk_base_reg + WAW'(f_idx)
                                                        : word_reg;
    assign bit_sum    = word_base_reg + BW'(f_idx);
    assign prod       = PW'(num_reg) * PW'(RECIP);
    assign quot       = prod >> SHK;
    assign word_first = NUMW'(word_reg * WORD_BITS);
    assign rem        = num_reg - word_first;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::ST_CLEAR: begin
                if (clr_addr_reg == WAW'(MAP_WORDS - 1)) begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser[0] == bba_pkg::ACT_ALLOC) ? bba_pkg::ST_SCAN
                                                                    : bba_pkg::ST_FDIV;
                end
            end
            bba_pkg::ST_SCAN: begin
                if (f_found) begin
                    state_next = bba_pkg::ST_ABIT;
                end else if (last_chunk) begin
                    state_next = bba_pkg::ST_DONE;
                end
            end
            bba_pkg::ST_ABIT: state_next = bba_pkg::ST_DONE;
            bba_pkg::ST_FDIV: begin
                if (XW'(num_reg) >= XW'(n_reg)) begin
                    state_next = bba_pkg::ST_DONE;
                end else begin
                    state_next = bba_pkg::ST_FRD;
                end
            end
            bba_pkg::ST_FRD:  state_next = bba_pkg::ST_FBIT;
            bba_pkg::ST_FBIT: state_next = bba_pkg::ST_DONE;
            bba_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            default: state_next = bba_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        clr_addr_next   = clr_addr_reg;
        chunk_next      = chunk_reg;
        chunk_base_next = chunk_base_reg;
        block_base_next = block_base_reg;
        word_next       = word_reg;
        word_base_next  = word_base_reg;
        bit_next        = bit_reg;
        num_next        = num_reg;
        n_next          = n_reg;
        used_next       = used_reg;
        full_next       = full_reg;
        res_block_next  = res_block_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = word_reg;
        wr_data         = rd_data;
        bit_mask        = '0;

        unique case (state_reg)
            bba_pkg::ST_CLEAR: begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            bba_pkg::ST_IDLE: begin
                if (s_accept) begin
                    num_next        = s_tdata[NUMW-1:0];
                    n_next          = managed;
                    chunk_next      = '0;
                    chunk_base_next = '0;
                    block_base_next = '0;
                    res_block_next  = '0;
                    res_status_next = bba_pkg::STAT_OK;
                end
            end
            bba_pkg::ST_SCAN: begin
                if (f_found) begin
                    word_next      = rd_addr;
                    word_base_next = block_base_reg + BW'(f_idx * WORD_BITS);
                end else if (last_chunk) begin
                    res_status_next = bba_pkg::STAT_FULL;
                end else begin
                    chunk_next      = chunk_reg + 1'b1;
                    chunk_base_next = chunk_base_reg + WAW'(WORD_BITS);
                    block_base_next = block_base_reg + BW'(WORD_BITS * WORD_BITS);
                end
            end
            bba_pkg::ST_ABIT: begin
                if (CNTW'(bit_sum) >= n_reg) begin
                    res_status_next = bba_pkg::STAT_FULL;
                end else begin
                    bit_mask            = WORD_BITS'(1) << f_idx;
                    wr_en               = 1'b1;
                    wr_data             = rd_data | bit_mask;
                    full_next[word_reg] = &(rd_data | bit_mask);
                    if (used_reg < CNTW'(MAP_BITS)) begin
                        used_next = used_reg + 1'b1;
                    end
                    res_block_next = NUMW'(bit_sum);
                end
            end
            bba_pkg::ST_FDIV: begin
                if (XW'(num_reg) >= XW'(n_reg)) begin
                    res_status_next = bba_pkg::STAT_RANGE;
                end else begin
                    word_next = WAW'(quot);
                end
            end
            bba_pkg::ST_FRD: begin
                bit_next = rem[IW-1:0];
            end
            bba_pkg::ST_FBIT: begin
                if (!rd_data[bit_reg]) begin
                    res_status_next = bba_pkg::STAT_ALREADY_FREE;
                end else begin
                    bit_mask            = WORD_BITS'(1) << bit_reg;
                    wr_en               = 1'b1;
                    wr_data             = rd_data & ~bit_mask;
                    full_next[word_reg] = 1'b0;
                    if (used_reg != '0) begin
                        used_next = used_reg - 1'b1;
                    end
                    res_block_next = num_reg;
                end
            end
            bba_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // output register
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_block_next  = out_block_reg;
        out_status_next = out_status_reg;
        out_free_next   = out_free_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next  = 1'b1;
            out_block_next  = res_block_reg;
            out_status_next = res_status_reg;
            out_free_next   = (n_reg > used_reg) ? bba_pkg::CNT_W'(n_reg - used_reg) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bba_pkg::ST_CLEAR;
            cfg_reg       <= bba_pkg::CFG_RESET;
            clr_addr_reg  <= '0;
            used_reg      <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            clr_addr_reg  <= clr_addr_next;
            used_reg      <= used_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chunk_reg      <= chunk_next;
        chunk_base_reg <= chunk_base_next;
        block_base_reg <= block_base_next;
        word_reg       <= word_next;
        word_base_reg  <= word_base_next;
        bit_reg        <= bit_next;
        num_reg        <= num_next;
        n_reg          <= n_next;
        res_block_reg  <= res_block_next;
        res_status_reg <= res_status_next;
        out_block_reg  <= out_block_next;
        out_status_reg <= out_status_next;
        out_free_reg   <= out_free_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = bba_pkg::M_TDATA_W'({out_free_reg, out_block_reg});

endmodule

`default_nettype wire

### test/block_bitmap_allocator_checker.sv
`timescale 1ns / 1ps
// Checker for block_bitmap_allocator_top: keeps its own copy of the block bitmap, used count
// and block count, predicts each grant/free result when a request beat is taken and compares
// it when the result beat leaves. Depends on bba_pkg.
module block_bitmap_allocator_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bba_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [bba_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [bba_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [bba_pkg::STAT_W-1:0]    m_tuser,
    output int                            mismatches,
    output int                            awaited,
    output int                            checked
);

    localparam int unsigned MAP_SIZE = 8192;
    localparam int BW = bba_pkg::BLOCK_W;
    localparam int CW = bba_pkg::CNT_W;

    typedef struct packed {
        logic [BW-1:0]              block;
        logic [bba_pkg::STAT_W-1:0] status;
        logic [CW-1:0]              free_cnt;
    } grant_t;

    bit            block_taken [MAP_SIZE];
    int unsigned   taken_cnt;
    logic [CW-1:0] block_limit;
    grant_t        grants_due [$];

    function automatic grant_t allocate_or_free(input logic act, input logic [BW-1:0] num);
        grant_t      r;
        int unsigned n;
        n = (block_limit > MAP_SIZE) ? MAP_SIZE : block_limit;
        r = '0;
        if (act == bba_pkg::ACT_ALLOC) begin
            r.status = bba_pkg::STAT_FULL;
            for (int unsigned b = 0; b < n; b++) begin
                if (!block_taken[b]) begin
                    block_taken[b] = 1'b1;
                    if (taken_cnt < MAP_SIZE) taken_cnt++;
                    r.block  = b[BW-1:0];
                    r.status = bba_pkg::STAT_OK;
                    break;
                end
            end
        end else if (num >= n) begin
            r.status = bba_pkg::STAT_RANGE;
        end else if (!block_taken[num]) begin
            r.status = bba_pkg::STAT_ALREADY_FREE;
        end else begin
            block_taken[num] = 1'b0;
            if (taken_cnt > 0) taken_cnt--;
            r.block  = num;
            r.status = bba_pkg::STAT_OK;
        end
        r.free_cnt = (n > taken_cnt) ? CW'(n - taken_cnt) : '0;
        return r;
    endfunction

    always @(posedge aclk) begin
        grant_t want;
        grant_t got;
        if (!aresetn) begin
            foreach (block_taken[i]) block_taken[i] = 1'b0;
            taken_cnt   = 0;
            block_limit = bba_pkg::CFG_RESET;
            grants_due.delete();
            mismatches  = 0;
            awaited     = 0;
            checked     = 0;
        end else begin
            if (cfg_we) block_limit = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got = {m_tdata[BW-1:0], m_tuser, m_tdata[BW+CW-1:BW]};
                if (grants_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result beat with no request waiting: %s %0d %0d %0d",
                                 $realtime, "block/status/free", got.block, got.status,
                                 got.free_cnt);
                    mismatches++;
                end else begin
                    want = grants_due.pop_front();
                    checked++;
                    if (got.block !== want.block || got.status !== want.status ||
                        got.free_cnt !== want.free_cnt) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch: block %0d/%0d status %0d/%0d %s",
                                     $realtime, want.block, got.block, want.status,
                                     got.status, "(exp/act)");
                        if (mismatches < 10)
                            $display("    free %0d/%0d (exp/act)",
                                     want.free_cnt, got.free_cnt);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                grants_due.push_back(allocate_or_free(s_tuser[0], s_tdata[BW-1:0]));
            awaited = grants_due.size();
        end
    end

endmodule

### test/block_bitmap_allocator_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for block_bitmap_allocator_top: clock, reset, request and block-count stimulus,
// random back-pressure and the verdict. Depends on bba_pkg, the allocator RTL and
// block_bitmap_allocator_checker.
module block_bitmap_allocator_top_tb;

    localparam int N_PHASES        = 9;
    localparam int ITEMS_PER_PHASE = 142;
    localparam int STALL_LIMIT     = 4000;
    localparam int SINK_HOLD       = 400;
    localparam int BW              = bba_pkg::BLOCK_W;
    localparam int CW              = bba_pkg::CNT_W;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [CW-1:0]                 cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [bba_pkg::S_TDATA_W-1:0] s_tdata;
    logic [0:0]                    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [bba_pkg::M_TDATA_W-1:0] m_tdata;
    logic [bba_pkg::STAT_W-1:0]    m_tuser;

    int mismatches;
    int awaited;
    int checked;

    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    bit          sink_hold_req;
    int          requests_sent;
    int          count_writes;

    int unsigned phase_cfg   [N_PHASES] = '{8192, 16, 64, 1, 200, 16383, 5, 0, 33};
    int unsigned phase_alloc [N_PHASES] = '{60, 70, 55, 50, 80, 40, 60, 50, 65};

    block_bitmap_allocator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    block_bitmap_allocator_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .awaited    (awaited),
        .checked    (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_request(input logic act, input logic [BW-1:0] num);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= bba_pkg::S_TDATA_W'(num);
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        requests_sent++;
    endtask

    // Drain every pending result, then write the block count.
    task automatic set_block_count(input int unsigned cnt);
        s_tvalid <= 1'b0;
        while (awaited != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cnt[CW-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        count_writes++;
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int            p;
        int            i;
        int unsigned   roll;
        int unsigned   span;
        logic [BW-1:0] num;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = bba_pkg::ACT_ALLOC;
        sink_hold_req = 1'b0;
        src_idle_pct  = 6;
        sink_idle_pct = 65;
        requests_sent = 0;
        count_writes  = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // full-size map after reset: first fit, frees, double free
        send_request(bba_pkg::ACT_ALLOC, '0);
        send_request(bba_pkg::ACT_ALLOC, '0);
        send_request(bba_pkg::ACT_ALLOC, '0);
        send_request(bba_pkg::ACT_FREE, 13'd1);
        send_request(bba_pkg::ACT_FREE, 13'd1);
        send_request(bba_pkg::ACT_ALLOC, 13'h1FFF);
        send_request(bba_pkg::ACT_FREE, 13'd8191);
        send_request(bba_pkg::ACT_FREE, 13'd0);
        send_request(bba_pkg::ACT_ALLOC, '0);
        // small map: out of range, fill up, full
        set_block_count(4);
        send_request(bba_pkg::ACT_FREE, 13'd5);
        send_request(bba_pkg::ACT_ALLOC, '0);
        send_request(bba_pkg::ACT_ALLOC, '0);
        send_request(bba_pkg::ACT_FREE, 13'd4);
        // count lowered below the blocks in use
        set_block_count(2);
        send_request(bba_pkg::ACT_ALLOC, '0);
        send_request(bba_pkg::ACT_FREE, 13'd3);
        send_request(bba_pkg::ACT_FREE, 13'd1);
        // nothing managed
        set_block_count(0);
        send_request(bba_pkg::ACT_ALLOC, '0);
        send_request(bba_pkg::ACT_FREE, 13'd0);
        // oversized count acts as the full map
        set_block_count(16383);
        send_request(bba_pkg::ACT_FREE, 13'd8191);
        send_request(bba_pkg::ACT_ALLOC, '0);
        set_block_count(1);
        send_request(bba_pkg::ACT_FREE, 13'd0);
        send_request(bba_pkg::ACT_ALLOC, '0);
        send_request(bba_pkg::ACT_ALLOC, '0);

        for (p = 0; p < N_PHASES; p++) begin
            src_idle_pct  = (p < 3) ? 6 : (p < 6) ? 65 : 0;
            sink_idle_pct = (p < 3) ? 65 : (p < 6) ? 6 : 0;
            set_block_count(phase_cfg[p]);
            if (p == 1) sink_hold_req = 1'b1;
            span = (phase_cfg[p] > 8190) ? 8191 : phase_cfg[p] + 1;
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < phase_alloc[p]) begin
                    send_request(bba_pkg::ACT_ALLOC, BW'($urandom_range(0, 8191)));
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70)
                        num = BW'($urandom_range(0, span));
                    else if (roll < 85)
                        num = BW'($urandom_range(0, 15));
                    else
                        num = BW'($urandom_range(0, 8191));
                    send_request(bba_pkg::ACT_FREE, num);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (awaited != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        $display("Sent %0d allocate/free requests across %0d block-count writes (0 to 16383),",
                 requests_sent, count_writes);
        $display("%0d results compared, with sender and receiver stalls and one long hold.",
                 checked);
        if (mismatches == 0 && awaited == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
design/bba_pkg.sv
design/bba_ram.sv
design/bba_find.sv
design/block_bitmap_allocator_top.sv
test/block_bitmap_allocator_checker.sv
test/block_bitmap_allocator_top_tb.sv
